// File: rtl/pmt_pkg.sv
// Package for the PS/2 mouse packet tracker.
// Shared widths, codes, register indexes and the command word type.
// No dependencies.
`default_nettype none

package pmt_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_FIELD_W = 16;
  localparam int BTN_W       = 3;
  localparam int SENS_W      = 8;
  localparam int LIMIT_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DELTA_W     = 19;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic CMD_MOVE  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_X     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_Y     = 2'd2;

  localparam logic [SENS_W-1:0]  SENS_RESET    = 8'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_X_RESET = 16'd640;
  localparam logic [LIMIT_W-1:0] LIMIT_Y_RESET = 16'd480;

  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;
  localparam logic [BYTE_W-1:0] OVF_MASK = 8'hC0;

  typedef struct packed {
    logic                   kind;
    logic                   axis;
    logic [POS_FIELD_W-1:0] npos;
    logic [BYTE_W-1:0]      flag_byte;
    logic [BYTE_W-1:0]      x_byte;
    logic [BYTE_W-1:0]      y_byte;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/pmt_in_if.sv
// Input channel of the packet tracker: valid/ready plus the item word.
// Depends on pmt_pkg.
`default_nettype none

interface pmt_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [pmt_pkg::BYTE_W-1:0]      rx_byte;
  logic                            axis_sel;
  logic [pmt_pkg::POS_FIELD_W-1:0] new_position;

  modport source (output valid, op, rx_byte, axis_sel, new_position, input ready);
  modport sink   (input valid, op, rx_byte, axis_sel, new_position, output ready);
endinterface

`default_nettype wire

// File: rtl/pmt_out_if.sv
// Result channel of the packet tracker: valid/ready plus the position word.
// Depends on pmt_pkg.
`default_nettype none

interface pmt_out_if;
  logic                            valid;
  logic                            ready;
  logic [pmt_pkg::POS_FIELD_W-1:0] pos_x;
  logic [pmt_pkg::POS_FIELD_W-1:0] pos_y;
  logic [pmt_pkg::BTN_W-1:0]       button_bits;

  modport source (output valid, pos_x, pos_y, button_bits, input ready);
  modport sink   (input valid, pos_x, pos_y, button_bits, output ready);
endinterface

`default_nettype wire

// File: rtl/pmt_front.sv
// Front end: accepts input words, tracks packet phase and emits commands.
// Depends on pmt_pkg and pmt_in_if.
`default_nettype none

module pmt_front (
  input  wire logic  clk,
  input  wire logic  rst,
  pmt_in_if.sink     item,
  input  wire logic  space,
  output pmt_pkg::cmd_t push_cmd,
  output logic       push_valid
);

  localparam logic [1:0] PHASE_FLAG = 2'd0;
  localparam logic [1:0] PHASE_X    = 2'd1;
  localparam logic [1:0] PHASE_Y    = 2'd2;

  logic [1:0]                 byte_phase;
  logic [1:0]                 byte_phase_next;
  logic [pmt_pkg::BYTE_W-1:0] flag_byte;
  logic [pmt_pkg::BYTE_W-1:0] x_byte;
  logic                       accept;

  assign item.ready = space;
  assign accept     = item.valid && space;

  always_comb begin
    byte_phase_next     = byte_phase;
    push_valid          = 1'b0;
    push_cmd.kind       = pmt_pkg::CMD_MOVE;
    push_cmd.axis       = item.axis_sel;
    push_cmd.npos       = item.new_position;
    push_cmd.flag_byte  = flag_byte;
    push_cmd.x_byte     = x_byte;
    push_cmd.y_byte     = item.rx_byte;
    if (accept) begin
      if (item.op == pmt_pkg::OP_WRITE) begin
        push_valid    = 1'b1;
        push_cmd.kind = pmt_pkg::CMD_WRITE;
      end else begin
        case (byte_phase)
          PHASE_FLAG: begin
            if (item.rx_byte[pmt_pkg::SYNC_BIT]) begin
              byte_phase_next = PHASE_X;
            end
          end
          PHASE_X: begin
            byte_phase_next = PHASE_Y;
          end
          default: begin
            byte_phase_next = PHASE_FLAG;
            push_valid      = ((flag_byte & pmt_pkg::OVF_MASK) == '0);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= PHASE_FLAG;
      flag_byte  <= '0;
      x_byte     <= '0;
    end else begin
      byte_phase <= byte_phase_next;
      if (accept && item.op == pmt_pkg::OP_BYTE) begin
        if (byte_phase == PHASE_FLAG && item.rx_byte[pmt_pkg::SYNC_BIT]) begin
          flag_byte <= item.rx_byte;
        end
        if (byte_phase == PHASE_X) begin
          x_byte <= item.rx_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pmt_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on pmt_pkg.
`default_nettype none

module pmt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire pmt_pkg::cmd_t push_cmd,
  output logic               space,
  output logic               pop_valid,
  output pmt_pkg::cmd_t      pop_cmd,
  input  wire logic          pop
);

  localparam int PTR_W = $clog2(pmt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pmt_pkg::QUEUE_DEPTH + 1);

  pmt_pkg::cmd_t    entries [pmt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign space     = (count != CNT_W'(pmt_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push_valid && space;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pmt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pmt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pmt_back.sv
// Back end: scales deltas, then adds and clamps into the pointer position, or loads a written position.
// Holds the configuration registers. Depends on pmt_pkg and pmt_out_if.
`default_nettype none

module pmt_back #(
  parameter int POS_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pmt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              pop_valid,
  input  wire pmt_pkg::cmd_t                     pop_cmd,
  output logic                                   pop,
  pmt_out_if.source                              result
);

  localparam int DW    = pmt_pkg::DELTA_W;
  localparam int SUM_W = ((POS_BITS > DW) ? POS_BITS : DW) + 2;

  logic [pmt_pkg::SENS_W-1:0]  sensitivity;
  logic [pmt_pkg::LIMIT_W-1:0] limit_x;
  logic [pmt_pkg::LIMIT_W-1:0] limit_y;

  logic                      a_valid;
  logic                      a_kind;
  logic                      a_axis;
  logic [POS_BITS-1:0]       a_npos;
  logic [pmt_pkg::BTN_W-1:0] a_buttons;
  logic signed [DW-1:0]      a_dx;
  logic signed [DW-1:0]      a_dy;

  logic signed [DW-1:0]      xs;
  logic signed [DW-1:0]      ys;
  logic signed [DW-1:0]      sens_s;
  logic signed [DW-1:0]      dx_next;
  logic signed [DW-1:0]      dy_next;
  logic                      a_ready;
  logic                      b_take;

  logic [POS_BITS-1:0]       cur_x;
  logic [POS_BITS-1:0]       cur_y;
  logic [pmt_pkg::BTN_W-1:0] held_buttons;
  logic                      out_valid;

  function automatic logic [POS_BITS-1:0] clamp_move(
    input logic [POS_BITS-1:0]         cur,
    input logic signed [DW-1:0]        delta,
    input logic [pmt_pkg::LIMIT_W-1:0] limit
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] top;
    sum = $signed({{(SUM_W-POS_BITS){1'b0}}, cur})
        + $signed({{(SUM_W-DW){delta[DW-1]}}, delta});
    top = $signed({{(SUM_W-POS_BITS){1'b0}}, {POS_BITS{1'b1}}});
    hi  = $signed({{(SUM_W-pmt_pkg::LIMIT_W){1'b0}}, limit});
    if (hi > top) begin
      hi = top;
    end
    if (sum[SUM_W-1]) begin
      sum = '0;
    end else if (sum > hi) begin
      sum = hi;
    end
    return sum[POS_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= pmt_pkg::SENS_RESET;
      limit_x     <= pmt_pkg::LIMIT_X_RESET;
      limit_y     <= pmt_pkg::LIMIT_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pmt_pkg::CFG_SENSITIVITY: sensitivity <= cfg_data[pmt_pkg::SENS_W-1:0];
        pmt_pkg::CFG_LIMIT_X:     limit_x     <= cfg_data[pmt_pkg::LIMIT_W-1:0];
        pmt_pkg::CFG_LIMIT_Y:     limit_y     <= cfg_data[pmt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Scale stage: sign-extend from the flag byte, negate Y, multiply.
  always_comb begin
    xs = $signed({{(DW-pmt_pkg::BYTE_W){pop_cmd.flag_byte[pmt_pkg::XSIGN_BIT]}},
                  pop_cmd.x_byte});
    ys = $signed({{(DW-pmt_pkg::BYTE_W){pop_cmd.flag_byte[pmt_pkg::YSIGN_BIT]}},
                  pop_cmd.y_byte});
    sens_s  = $signed({{(DW-pmt_pkg::SENS_W){1'b0}}, sensitivity});
    dx_next = xs * sens_s;
    dy_next = (-ys) * sens_s;
  end

  assign out_valid = result.valid;
  assign b_take    = a_valid && (!out_valid || result.ready);
  assign a_ready   = !a_valid || b_take;
  assign pop       = pop_valid && a_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      a_kind    <= pop_cmd.kind;
      a_axis    <= pop_cmd.axis;
      a_npos    <= POS_BITS'(pop_cmd.npos);
      a_buttons <= pop_cmd.flag_byte[pmt_pkg::BTN_W-1:0];
      a_dx      <= dx_next;
      a_dy      <= dy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop_valid;
    end
  end

  // Position stage: the result word shows the position registers directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      held_buttons <= '0;
      result.valid <= 1'b0;
    end else begin
      if (b_take) begin
        result.valid <= 1'b1;
        if (a_kind == pmt_pkg::CMD_WRITE) begin
          if (a_axis == pmt_pkg::AXIS_X) begin
            cur_x <= a_npos;
          end else begin
            cur_y <= a_npos;
          end
        end else begin
          cur_x        <= clamp_move(cur_x, a_dx, limit_x);
          cur_y        <= clamp_move(cur_y, a_dy, limit_y);
          held_buttons <= a_buttons;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  assign result.pos_x       = pmt_pkg::POS_FIELD_W'(cur_x);
  assign result.pos_y       = pmt_pkg::POS_FIELD_W'(cur_y);
  assign result.button_bits = held_buttons;

endmodule

`default_nettype wire

// File: rtl/ps2_mouse_packet_tracker_top.sv
// PS/2 mouse packet tracker, top level.
// Channels: item (sink) takes one word per handshake: op 0 carries a mouse
// byte in rx_byte, op 1 writes new_position to the axis chosen by axis_sel.
// result (source) gives pos_x, pos_y and button_bits after every accepted
// packet with no overflow bit and after every position write.
// Configuration: cfg_we/cfg_index/cfg_data write sensitivity (0), limit_x (1)
// and limit_y (2); write only while the block is idle.
// A result word passes through the command queue, the scale-stage register and
// the position registers before it is valid.
// Throughput: one item per cycle while result is not stalled, set by the scale
// stage and the add-and-clamp stage in the back end.
// Reset: positions, buttons and packet phase clear to zero, sensitivity to 1,
// limits to 640 and 480; item.ready rises in the first cycle after reset.
// Stall: while result is held, the word stays stable; the scale stage and a
// two-entry command queue keep absorbing items, then item.ready drops.
// POS_BITS sets the width of the stored positions.
`default_nettype none

module ps2_mouse_packet_tracker_top #(
  parameter int POS_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pmt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pmt_pkg::CFG_DATA_W-1:0]  cfg_data,
  pmt_in_if.sink                               item,
  pmt_out_if.source                            result
);

  pmt_pkg::cmd_t push_cmd;
  pmt_pkg::cmd_t pop_cmd;
  logic          push_valid;
  logic          space;
  logic          pop_valid;
  logic          pop;

  pmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .space      (space),
    .push_cmd   (push_cmd),
    .push_valid (push_valid)
  );

  pmt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .space      (space),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  pmt_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

// File: rtl/pmt_checker.sv
// Port-level checks for the packet tracker, bound to the top level.
// Depends on pmt_pkg and ps2_mouse_packet_tracker_top.
`default_nettype none

module pmt_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            item_valid,
  input wire logic                            item_ready,
  input wire logic                            result_valid,
  input wire logic                            result_ready,
  input wire logic [pmt_pkg::POS_FIELD_W-1:0] pos_x,
  input wire logic [pmt_pkg::POS_FIELD_W-1:0] pos_y,
  input wire logic [pmt_pkg::BTN_W-1:0]       button_bits
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("reset did not clear the result side or open the input");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(pos_x) && $stable(pos_y) && $stable(button_bits))
    else $error("stalled result word changed");

  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("input closed while the result side was empty");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
      |-> $past(item_valid && item_ready, 3))
    else $error("result word appeared without an item three cycles earlier");

endmodule

bind ps2_mouse_packet_tracker_top pmt_checker u_pmt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .pos_x        (result.pos_x),
  .pos_y        (result.pos_y),
  .button_bits  (result.button_bits)
);

`default_nettype wire

// File: test/tb_ps2_mouse_packet_tracker_top.sv
`timescale 1ns / 1ps
// Testbench for ps2_mouse_packet_tracker_top: directed and random mouse traffic
// checked word by word against an in-bench pointer tracker.
// Depends on pmt_pkg, pmt_in_if, pmt_out_if and the RTL top level.

module tb_ps2_mouse_packet_tracker_top;

  localparam int POS_BITS    = 16;
  localparam int POS_MAX     = (1 << POS_BITS) - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYC  = 4;

  typedef struct packed {
    logic                            op;
    logic [pmt_pkg::BYTE_W-1:0]      rx_byte;
    logic                            axis_sel;
    logic [pmt_pkg::POS_FIELD_W-1:0] new_position;
  } mouse_word_t;

  typedef struct packed {
    logic [pmt_pkg::POS_FIELD_W-1:0] pos_x;
    logic [pmt_pkg::POS_FIELD_W-1:0] pos_y;
    logic [pmt_pkg::BTN_W-1:0]       button_bits;
  } pointer_state_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [pmt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pmt_pkg::CFG_DATA_W-1:0]  cfg_data;

  pmt_in_if  item_ch ();
  pmt_out_if result_ch ();

  ps2_mouse_packet_tracker_top #(.POS_BITS(POS_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // tracker copy of the block's settings and state
  logic [pmt_pkg::SENS_W-1:0]  sens_reg;
  logic [pmt_pkg::LIMIT_W-1:0] lim_x_reg;
  logic [pmt_pkg::LIMIT_W-1:0] lim_y_reg;
  logic [1:0]                  pkt_phase;
  logic [pmt_pkg::BYTE_W-1:0]  lead_byte;
  logic [pmt_pkg::BYTE_W-1:0]  move_x_byte;
  logic [POS_BITS-1:0]         track_x;
  logic [POS_BITS-1:0]         track_y;
  logic [pmt_pkg::BTN_W-1:0]   track_buttons;

  pointer_state_t expected_positions[$];
  int             mismatch_count;
  int             words_sent;
  int             cycle_count;
  bit             quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_axis(int cur, int delta, int lim);
    int top;
    int sum;
    top = (lim > POS_MAX) ? POS_MAX : lim;
    sum = cur + delta;
    if (sum < 0) sum = 0;
    if (sum > top) sum = top;
    return sum;
  endfunction

  function automatic void track_word(mouse_word_t w);
    int dx;
    int dy;
    if (w.op == pmt_pkg::OP_WRITE) begin
      if (w.axis_sel == pmt_pkg::AXIS_X) track_x = w.new_position[POS_BITS-1:0];
      else track_y = w.new_position[POS_BITS-1:0];
      expected_positions.push_back({pmt_pkg::POS_FIELD_W'(track_x),
                                    pmt_pkg::POS_FIELD_W'(track_y), track_buttons});
      return;
    end
    case (pkt_phase)
      2'd0: begin
        if (w.rx_byte[pmt_pkg::SYNC_BIT]) begin
          lead_byte = w.rx_byte;
          pkt_phase = 2'd1;
        end
      end
      2'd1: begin
        move_x_byte = w.rx_byte;
        pkt_phase   = 2'd2;
      end
      default: begin
        pkt_phase = 2'd0;
        if ((lead_byte & pmt_pkg::OVF_MASK) == '0) begin
          dx = int'(move_x_byte) - (lead_byte[pmt_pkg::XSIGN_BIT] ? 256 : 0);
          dy = -(int'(w.rx_byte) - (lead_byte[pmt_pkg::YSIGN_BIT] ? 256 : 0));
          dx = dx * int'(sens_reg);
          dy = dy * int'(sens_reg);
          track_buttons = lead_byte[pmt_pkg::BTN_W-1:0];
          track_x = POS_BITS'(clamp_axis(int'(track_x), dx, int'(lim_x_reg)));
          track_y = POS_BITS'(clamp_axis(int'(track_y), dy, int'(lim_y_reg)));
          expected_positions.push_back({pmt_pkg::POS_FIELD_W'(track_x),
                                        pmt_pkg::POS_FIELD_W'(track_y), track_buttons});
        end
      end
    endcase
  endfunction

  function automatic mouse_word_t byte_word(logic [pmt_pkg::BYTE_W-1:0] b);
    mouse_word_t w;
    w.op           = pmt_pkg::OP_BYTE;
    w.rx_byte      = b;
    w.axis_sel     = 1'($urandom_range(0, 1));
    w.new_position = pmt_pkg::POS_FIELD_W'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic mouse_word_t write_word(logic axis,
                                             logic [pmt_pkg::POS_FIELD_W-1:0] p);
    mouse_word_t w;
    w.op           = pmt_pkg::OP_WRITE;
    w.rx_byte      = pmt_pkg::BYTE_W'($urandom_range(0, 255));
    w.axis_sel     = axis;
    w.new_position = p;
    return w;
  endfunction

  task automatic send_word(mouse_word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.op           <= w.op;
    item_ch.rx_byte      <= w.rx_byte;
    item_ch.axis_sel     <= w.axis_sel;
    item_ch.new_position <= w.new_position;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    track_word(w);
    words_sent++;
  endtask

  task automatic send_bytes(logic [pmt_pkg::BYTE_W-1:0] b0,
                            logic [pmt_pkg::BYTE_W-1:0] b1,
                            logic [pmt_pkg::BYTE_W-1:0] b2);
    send_word(byte_word(b0));
    send_word(byte_word(b1));
    send_word(byte_word(b2));
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_setting(logic [pmt_pkg::CFG_INDEX_W-1:0] idx,
                               logic [pmt_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      pmt_pkg::CFG_SENSITIVITY: sens_reg  = data[pmt_pkg::SENS_W-1:0];
      pmt_pkg::CFG_LIMIT_X:     lim_x_reg = data[pmt_pkg::LIMIT_W-1:0];
      pmt_pkg::CFG_LIMIT_Y:     lim_y_reg = data[pmt_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_sync_drop();
    send_word(byte_word(8'h00));
    send_word(byte_word(8'hF7));
    send_bytes(8'h0F, 8'h7F, 8'h80);
  endtask

  task automatic test_delta_extremes();
    send_bytes(8'h38, 8'h00, 8'hFF);
    send_bytes(8'h08, 8'hFF, 8'h00);
  endtask

  task automatic test_overflow_drop();
    send_bytes(8'h4F, 8'h10, 8'h10);
    send_bytes(8'hB8, 8'hF0, 8'h0F);
  endtask

  task automatic test_write_beyond_limit();
    send_word(write_word(pmt_pkg::AXIS_X, 16'hFFFF));
    send_bytes(8'h08, 8'h00, 8'h00);
  endtask

  task automatic test_write_mid_packet();
    send_word(byte_word(8'h09));
    send_word(write_word(pmt_pkg::AXIS_X, 16'd100));
    send_word(byte_word(8'h05));
    send_word(write_word(pmt_pkg::AXIS_Y, 16'd50));
    send_word(byte_word(8'hFB));
  endtask

  task automatic test_random_traffic(int sens, int lim_x, int lim_y, int n, bit no_gaps);
    int          stop_at;
    int          pick;
    int          slot;
    int          k;
    logic [7:0]  pkt[3];
    logic        axis;
    int          lim;
    settle();
    write_setting(pmt_pkg::CFG_SENSITIVITY, pmt_pkg::CFG_DATA_W'(sens));
    write_setting(pmt_pkg::CFG_LIMIT_X, pmt_pkg::CFG_DATA_W'(lim_x));
    write_setting(pmt_pkg::CFG_LIMIT_Y, pmt_pkg::CFG_DATA_W'(lim_y));
    cfg_we  <= 1'b0;
    quiet   = no_gaps;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      axis = 1'($urandom_range(0, 1));
      lim  = axis ? int'(lim_y_reg) : int'(lim_x_reg);
      if (pick < 70) begin
        pkt[0] = pmt_pkg::BYTE_W'($urandom_range(0, 255));
        pkt[0][pmt_pkg::SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 7) != 0) pkt[0] = pkt[0] & ~pmt_pkg::OVF_MASK;
        pkt[1] = pmt_pkg::BYTE_W'($urandom_range(0, 255));
        pkt[2] = pmt_pkg::BYTE_W'($urandom_range(0, 255));
        slot = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1)) : -1;
        for (k = 0; k < 3; k++) begin
          send_word(byte_word(pkt[k]));
          if (k == slot)
            send_word(write_word(axis, pmt_pkg::POS_FIELD_W'($urandom_range(0, lim))));
        end
      end else if (pick < 82) begin
        if ($urandom_range(0, 3) == 0)
          send_word(write_word(axis, pmt_pkg::POS_FIELD_W'($urandom_range(0, 65535))));
        else
          send_word(write_word(axis, pmt_pkg::POS_FIELD_W'($urandom_range(0, lim))));
      end else if (pick < 92) begin
        send_word(byte_word(pmt_pkg::BYTE_W'($urandom_range(0, 255))));
      end else begin
        pkt[0] = pmt_pkg::BYTE_W'($urandom_range(0, 255));
        pkt[0][pmt_pkg::SYNC_BIT] = 1'b1;
        send_word(byte_word(pkt[0]));
        if ($urandom_range(0, 1) == 0)
          send_word(byte_word(pmt_pkg::BYTE_W'($urandom_range(0, 255))));
      end
    end
  endtask

  // result side stalls in random bursts unless quiet is set
  initial begin : result_pacing
    int run;
    run = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        if (quiet) begin
          result_ch.ready <= 1'b1;
          run = 1;
        end else if ($urandom_range(0, 2) == 0) begin
          result_ch.ready <= 1'b0;
          run = $urandom_range(1, 11);
        end else begin
          result_ch.ready <= 1'b1;
          run = $urandom_range(1, 24);
        end
      end
      run--;
    end
  end

  always @(posedge clk) begin : result_check
    pointer_state_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_positions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: x=%0d y=%0d buttons=%0h",
                   result_ch.pos_x, result_ch.pos_y, result_ch.button_bits);
      end else begin
        want = expected_positions.pop_front();
        if (result_ch.pos_x !== want.pos_x || result_ch.pos_y !== want.pos_y ||
            result_ch.button_bits !== want.button_bits) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"word mismatch: want x=%0d y=%0d buttons=%0h, ",
                      "got x=%0d y=%0d buttons=%0h"},
                     want.pos_x, want.pos_y, want.button_bits,
                     result_ch.pos_x, result_ch.pos_y, result_ch.button_bits);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ps2_mouse_packet_tracker_top: mismatch");
      $finish;
    end
  end

  initial begin
    cycle_count          = 0;
    mismatch_count       = 0;
    words_sent           = 0;
    quiet                = 1'b0;
    sens_reg             = pmt_pkg::SENS_RESET;
    lim_x_reg            = pmt_pkg::LIMIT_X_RESET;
    lim_y_reg            = pmt_pkg::LIMIT_Y_RESET;
    pkt_phase            = 2'd0;
    lead_byte            = '0;
    move_x_byte          = '0;
    track_x              = '0;
    track_y              = '0;
    track_buttons        = '0;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.op           <= pmt_pkg::OP_BYTE;
    item_ch.rx_byte      <= '0;
    item_ch.axis_sel     <= pmt_pkg::AXIS_X;
    item_ch.new_position <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_sync_drop();
    test_delta_extremes();
    test_overflow_drop();
    test_write_beyond_limit();
    test_write_mid_packet();

    test_random_traffic(0, 65535, 0, 300, 1'b0);
    test_random_traffic(255, 65535, 65535, 300, 1'b0);
    test_random_traffic(255, 0, 0, 300, 1'b0);
    test_random_traffic($urandom_range(1, 8), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), 300, 1'b0);
    test_random_traffic($urandom_range(0, 255), 640, 480, 300, 1'b0);
    test_random_traffic(2, 1023, 767, 300, 1'b1);

    settle();
    if (mismatch_count == 0) begin
      $display("ps2_mouse_packet_tracker_top: match");
    end else begin
      $display("ps2_mouse_packet_tracker_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pmt_pkg.sv
rtl/pmt_in_if.sv
rtl/pmt_out_if.sv
rtl/pmt_front.sv
rtl/pmt_queue.sv
rtl/pmt_back.sv
rtl/ps2_mouse_packet_tracker_top.sv
rtl/pmt_checker.sv
test/tb_ps2_mouse_packet_tracker_top.sv
